// ===== design/page_frame_buffer_lru_assert.svh =====
// ---------------------------------------------------------------------------
// Page frame buffer LRU - assertion macros
// Concurrent assertion wrappers clocked on i_clk, disabled while i_rst_n low.
// ---------------------------------------------------------------------------
`ifndef PAGE_FRAME_BUFFER_LRU_ASSERT_SVH
`define PAGE_FRAME_BUFFER_LRU_ASSERT_SVH

// same-cycle implication
`define PFB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PFB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pfb_pkg.sv =====
// ---------------------------------------------------------------------------
// pfb_pkg
// Shared constants, request codes and control structs for the frame buffer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfb_pkg;

    localparam int FRAMES_DEF       = 16;
    localparam int PAGE_ID_BITS_DEF = 24;
    localparam int PIN_BITS_DEF     = 8;
    localparam int MAX_RESULTS      = 16;

    typedef enum logic [2:0] {
        KIND_FETCH     = 3'd0,
        KIND_UNPIN     = 3'd1,
        KIND_FLUSH     = 3'd2,
        KIND_NEW       = 3'd3,
        KIND_DELETE    = 3'd4,
        KIND_FLUSH_ALL = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        REC_NOP,
        REC_REMOVE,
        REC_PUSH,
        REC_POP
    } t_rec_op;

    typedef struct packed {
        logic    start;
        t_rec_op op;
    } t_rec_cmd;

    typedef struct packed {
        logic done;
        logic nonempty;
    } t_rec_rsp;

    typedef struct packed {
        logic pop;
        logic push;
    } t_free_cmd;

endpackage

`default_nettype wire

// ===== design/pfb_ram.sv =====
// ---------------------------------------------------------------------------
// pfb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/pfb_free_fifo.sv =====
// ---------------------------------------------------------------------------
// pfb_free_fifo
// Circular FIFO of free frame indices. Until the head has gone round once,
// the slot at the head has never been written, and the head index is given out instead.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfb_free_fifo
    import pfb_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEF,
    localparam int IDX_W = $clog2(FRAMES)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_free_cmd        i_cmd,
    input  wire logic [IDX_W-1:0] i_push_frame,
    output logic      [IDX_W-1:0] o_head_frame,
    output logic      [IDX_W:0]   o_count
);

    logic [IDX_W-1:0] r_head;
    logic [IDX_W:0]   r_count;
    logic             r_lap;

    logic [IDX_W:0]   tail_sum;
    logic [IDX_W:0]   tail_wrap;
    logic [IDX_W-1:0] tail;
    logic [IDX_W-1:0] head_next;
    logic [IDX_W-1:0] rdata;
    logic             do_pop;
    logic             do_push;

    assign do_pop    = i_cmd.pop && (r_count != '0);
    assign do_push   = i_cmd.push && (r_count != (IDX_W+1)'(FRAMES));
    assign tail_sum  = {1'b0, r_head} + r_count;
    assign tail_wrap = (tail_sum >= (IDX_W+1)'(FRAMES)) ? tail_sum - (IDX_W+1)'(FRAMES)
                                                         : tail_sum;
    assign tail      = tail_wrap[IDX_W-1:0];
    assign head_next = (r_head == IDX_W'(FRAMES - 1)) ? '0 : r_head + 1'b1;

    pfb_ram #(
        .WIDTH (IDX_W),
        .DEPTH (FRAMES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (do_push),
        .i_waddr (tail),
        .i_wdata (i_push_frame),
        .i_raddr (r_head),
        .o_rdata (rdata)
    );

    assign o_head_frame = r_lap ? rdata : r_head;
    assign o_count      = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= (IDX_W+1)'(FRAMES);
            r_lap   <= 1'b0;
        end else begin
            if (do_pop) begin
                r_head <= head_next;
                if (r_head == IDX_W'(FRAMES - 1)) begin
                    r_lap <= 1'b1;
                end
            end
            if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end else if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/pfb_recency.sv =====
// ---------------------------------------------------------------------------
// pfb_recency
// Recency list of unpinned frames, most recent at position 0. Insert and
// remove walk the list one entry a cycle through a pipelined RAM read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfb_recency
    import pfb_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEF,
    localparam int IDX_W = $clog2(FRAMES)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_rec_cmd         i_cmd,
    input  wire logic [IDX_W-1:0] i_frame,
    output t_rec_rsp              o_rsp,
    output logic      [IDX_W-1:0] o_frame
);

`include "page_frame_buffer_lru_assert.svh"

    typedef enum logic [2:0] {
        R_IDLE,
        R_UP,
        R_RM,
        R_POP,
        R_POP_D,
        R_ACK
    } t_rstate;

    t_rstate          r_state, n_state;
    logic [IDX_W:0]   r_count, n_count;
    logic [FRAMES-1:0] r_in, n_in;
    logic [IDX_W-1:0] r_ptr, n_ptr;
    logic [IDX_W:0]   r_left, n_left;
    logic             r_dvld, n_dvld;
    logic [IDX_W-1:0] r_daddr, n_daddr;
    logic             r_found, n_found;
    logic [IDX_W-1:0] r_f, n_f;

    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
    logic [IDX_W-1:0] rdata;
    logic [IDX_W:0]   cnt_m1;
    logic             issue;
    logic             done;

    assign cnt_m1 = r_count - 1'b1;
    assign issue  = (r_left != '0);

    pfb_ram #(
        .WIDTH (IDX_W),
        .DEPTH (FRAMES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_in    = r_in;
        n_ptr   = r_ptr;
        n_left  = r_left;
        n_dvld  = r_dvld;
        n_daddr = r_daddr;
        n_found = r_found;
        n_f     = r_f;
        we      = 1'b0;
        waddr   = r_daddr;
        wdata   = rdata;
        raddr   = r_ptr;
        done    = 1'b0;

        case (r_state)
            R_IDLE: begin
                if (i_cmd.start) begin
                    n_f    = i_frame;
                    n_dvld = 1'b0;
                    case (i_cmd.op)
                        REC_PUSH: begin
                            if (!r_in[i_frame]) begin
                                n_ptr   = cnt_m1[IDX_W-1:0];
                                n_left  = r_count;
                                n_state = R_UP;
                            end else begin
                                n_state = R_ACK;
                            end
                        end
                        REC_REMOVE: begin
                            if (r_in[i_frame]) begin
                                n_ptr   = '0;
                                n_left  = r_count;
                                n_found = 1'b0;
                                n_state = R_RM;
                            end else begin
                                n_state = R_ACK;
                            end
                        end
                        REC_POP: begin
                            n_state = (r_count != '0) ? R_POP : R_ACK;
                        end
                        default: begin
                            n_state = R_ACK;
                        end
                    endcase
                end
            end

            // shift entries one place towards the tail, last entry first
            R_UP: begin
                if (issue) begin
                    n_ptr  = r_ptr - 1'b1;
                    n_left = r_left - 1'b1;
                end
                n_dvld  = issue;
                n_daddr = r_ptr;
                if (r_dvld) begin
                    we    = 1'b1;
                    waddr = r_daddr + 1'b1;
                    wdata = rdata;
                end else if (!issue) begin
                    we          = 1'b1;
                    waddr       = '0;
                    wdata       = r_f;
                    n_count     = r_count + 1'b1;
                    n_in[r_f]   = 1'b1;
                    done        = 1'b1;
                    n_state     = R_IDLE;
                end
            end

            // walk from the head; after the match each entry moves up one place
            R_RM: begin
                if (issue) begin
                    n_ptr  = r_ptr + 1'b1;
                    n_left = r_left - 1'b1;
                end
                n_dvld  = issue;
                n_daddr = r_ptr;
                if (r_dvld) begin
                    if (r_found) begin
                        we    = 1'b1;
                        waddr = r_daddr - 1'b1;
                        wdata = rdata;
                    end
                    if (rdata == r_f) begin
                        n_found = 1'b1;
                    end
                end else if (!issue) begin
                    n_count   = r_count - 1'b1;
                    n_in[r_f] = 1'b0;
                    done      = 1'b1;
                    n_state   = R_IDLE;
                end
            end

            R_POP: begin
                raddr   = cnt_m1[IDX_W-1:0];
                n_state = R_POP_D;
            end

            R_POP_D: begin
                n_count     = r_count - 1'b1;
                n_in[rdata] = 1'b0;
                done        = 1'b1;
                n_state     = R_IDLE;
            end

            R_ACK: begin
                done    = 1'b1;
                n_state = R_IDLE;
            end

            default: begin
                n_state = R_IDLE;
            end
        endcase
    end

    assign o_rsp.done     = done;
    assign o_rsp.nonempty = (r_count != '0);
    assign o_frame        = rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
            r_count <= '0;
            r_in    <= '0;
            r_left  <= '0;
            r_dvld  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_in    <= n_in;
            r_left  <= n_left;
            r_dvld  <= n_dvld;
            r_found <= n_found;
        end
        r_ptr   <= n_ptr;
        r_daddr <= n_daddr;
        r_f     <= n_f;
    end

    `PFB_ASSERT_IMP(a_rec_count_matches, r_state == R_IDLE, $countones(r_in) == int'(r_count), "recency count out of step with membership")
    `PFB_ASSERT_IMP(a_rec_cmd_when_idle, i_cmd.start, r_state == R_IDLE, "recency command while list busy")
    `PFB_ASSERT_IMP(a_rec_pop_nonempty, i_cmd.start && (i_cmd.op == REC_POP), r_count != '0, "pop from empty recency list")

endmodule

`default_nettype wire

// ===== design/page_frame_buffer_lru.sv =====
// ---------------------------------------------------------------------------
// page_frame_buffer_lru
// Frame metadata manager for a page buffer pool: tag lookup, pin counts,
// dirty marks, free-frame FIFO and least-recently-unpinned victim choice.
// ---------------------------------------------------------------------------
//  Channel   Handshake                Payload
//  request   start && !busy           i_kind, i_page_id, i_mark_dirty
//  result    o_valid (one cycle)      o_ok, o_frame, o_write_back,
//                                     o_write_back_page, o_load_from_disk,
//                                     o_zero_fill, o_last
//
//  Every request except flush_all and unknown codes first scans the tag RAM,
//  one frame a cycle, until the first hit.
//  A recency list insert or remove is awaited in S_WAIT_REC; a recency victim is
//  popped via S_WAIT_POP, and installing passes through S_INST_RD and S_INST_WR.
//  flush_all gives one result per dirty frame up to MAX_RESULTS, else one.
//  Results are not back-pressured; busy stays high until the last result.
//  Reset is synchronous; no clearing pass is needed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module page_frame_buffer_lru
    import pfb_pkg::*;
#(
    parameter int FRAMES       = FRAMES_DEF,
    parameter int PAGE_ID_BITS = PAGE_ID_BITS_DEF,
    parameter int PIN_BITS     = PIN_BITS_DEF,
    localparam int IDX_W       = $clog2(FRAMES)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [2:0]              i_kind,
    input  wire logic [PAGE_ID_BITS-1:0] i_page_id,
    input  wire logic                    i_mark_dirty,
    output logic                         o_valid,
    output logic                         o_ok,
    output logic      [IDX_W-1:0]        o_frame,
    output logic                         o_write_back,
    output logic      [PAGE_ID_BITS-1:0] o_write_back_page,
    output logic                         o_load_from_disk,
    output logic                         o_zero_fill,
    output logic                         o_last
);

`include "page_frame_buffer_lru_assert.svh"

    localparam int RAM_W = PIN_BITS + PAGE_ID_BITS;
    localparam int K_W   = $clog2(MAX_RESULTS);
    localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};
    localparam logic [PIN_BITS-1:0] PIN_ONE = PIN_BITS'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ACT,
        S_WAIT_REC,
        S_WAIT_POP,
        S_INST_RD,
        S_INST_WR,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic                    ok;
        logic [IDX_W-1:0]        frame;
        logic                    wb;
        logic [PAGE_ID_BITS-1:0] wbp;
        logic                    load;
        logic                    zero;
        logic                    last;
    } t_result;

    function automatic t_result mk_res(
        input logic                    ok,
        input logic [IDX_W-1:0]        frame,
        input logic                    wb,
        input logic [PAGE_ID_BITS-1:0] wbp,
        input logic                    load,
        input logic                    zero,
        input logic                    last
    );
        t_result res;
        res.ok    = ok;
        res.frame = frame;
        res.wb    = wb;
        res.wbp   = wbp;
        res.load  = load;
        res.zero  = zero;
        res.last  = last;
        return res;
    endfunction

    t_state                  r_state, n_state;
    logic [2:0]              r_kind, n_kind;
    logic [PAGE_ID_BITS-1:0] r_pid, n_pid;
    logic                    r_mark, n_mark;
    logic [IDX_W-1:0]        r_ptr, n_ptr;
    logic [IDX_W:0]          r_left, n_left;
    logic                    r_dvld, n_dvld;
    logic [IDX_W-1:0]        r_daddr, n_daddr;
    logic                    r_hit, n_hit;
    logic [IDX_W-1:0]        r_f, n_f;
    logic [PIN_BITS-1:0]     r_pin, n_pin;
    logic [PAGE_ID_BITS-1:0] r_tag, n_tag;
    logic [IDX_W-1:0]        r_v, n_v;
    logic [FRAMES-1:0]       r_valid, n_valid;
    logic [FRAMES-1:0]       r_dirty, n_dirty;
    logic [K_W-1:0]          r_k, n_k;
    logic                    r_o_valid, n_o_valid;
    t_result                 r_res, n_res;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [RAM_W-1:0]        ram_wdata;
    logic [IDX_W-1:0]        ram_raddr;
    logic [RAM_W-1:0]        ram_rdata;
    logic [PAGE_ID_BITS-1:0] rd_tag;
    logic [PIN_BITS-1:0]     rd_pin;

    t_rec_cmd                rec_cmd;
    t_rec_rsp                rec_rsp;
    logic [IDX_W-1:0]        rec_frame;
    t_free_cmd               free_cmd;
    logic [IDX_W-1:0]        free_head;
    logic [IDX_W:0]          free_count;

    logic [FRAMES-1:0]       vd;
    logic                    more_dirty;
    logic                    issue;
    logic [PIN_BITS-1:0]     pin_inc;
    logic [PIN_BITS-1:0]     pin_dec;
    logic                    inst_wb;
    logic                    flush_last;

    assign rd_tag  = ram_rdata[PAGE_ID_BITS-1:0];
    assign rd_pin  = ram_rdata[RAM_W-1:PAGE_ID_BITS];
    assign vd      = r_valid & r_dirty;
    assign issue   = (r_left != '0);
    assign pin_inc = (r_pin == PIN_MAX) ? r_pin : r_pin + 1'b1;
    assign pin_dec = r_pin - 1'b1;
    assign inst_wb = r_valid[r_v] && r_dirty[r_v];
    assign ram_raddr  = (r_state == S_INST_RD) ? r_v : r_ptr;
    assign flush_last = !more_dirty || (r_k == K_W'(MAX_RESULTS - 1));

    // any dirty frame above the one now being reported
    always_comb begin
        more_dirty = 1'b0;
        for (int j = 0; j < FRAMES; j++) begin
            if (vd[j] && (j > int'(r_daddr))) begin
                more_dirty = 1'b1;
            end
        end
    end

    pfb_ram #(
        .WIDTH (RAM_W),
        .DEPTH (FRAMES)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    pfb_free_fifo #(
        .FRAMES (FRAMES)
    ) u_free (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (free_cmd),
        .i_push_frame (r_f),
        .o_head_frame (free_head),
        .o_count      (free_count)
    );

    pfb_recency #(
        .FRAMES (FRAMES)
    ) u_recency (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (rec_cmd),
        .i_frame (r_f),
        .o_rsp   (rec_rsp),
        .o_frame (rec_frame)
    );

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_pid     = r_pid;
        n_mark    = r_mark;
        n_ptr     = r_ptr;
        n_left    = r_left;
        n_dvld    = r_dvld;
        n_daddr   = r_daddr;
        n_hit     = r_hit;
        n_f       = r_f;
        n_pin     = r_pin;
        n_tag     = r_tag;
        n_v       = r_v;
        n_valid   = r_valid;
        n_dirty   = r_dirty;
        n_k       = r_k;
        n_o_valid = 1'b0;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_waddr = r_f;
        ram_wdata = {r_pin, r_tag};
        rec_cmd.start = 1'b0;
        rec_cmd.op    = REC_NOP;
        free_cmd.pop  = 1'b0;
        free_cmd.push = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_kind = i_kind;
                    n_pid  = i_page_id;
                    n_mark = i_mark_dirty;
                    n_ptr  = '0;
                    n_left = (IDX_W+1)'(FRAMES);
                    n_dvld = 1'b0;
                    n_k    = '0;
                    case (i_kind)
                        KIND_FETCH, KIND_UNPIN, KIND_FLUSH, KIND_NEW, KIND_DELETE: begin
                            n_state = S_SCAN;
                        end
                        KIND_FLUSH_ALL: begin
                            if (vd == '0) begin
                                n_o_valid = 1'b1;
                                n_res     = mk_res(1'b1, '0, 1'b0, '0, 1'b0, 1'b0, 1'b1);
                            end else begin
                                n_state = S_FLUSH;
                            end
                        end
                        default: begin
                            n_o_valid = 1'b1;
                            n_res     = mk_res(1'b0, '0, 1'b0, '0, 1'b0, 1'b0, 1'b1);
                        end
                    endcase
                end
            end

            // tag search: each address is read in the cycle before its compare
            S_SCAN: begin
                if (issue) begin
                    n_ptr  = r_ptr + 1'b1;
                    n_left = r_left - 1'b1;
                end
                n_dvld  = issue;
                n_daddr = r_ptr;
                if (r_dvld && r_valid[r_daddr] && (rd_tag == r_pid)) begin
                    n_hit   = 1'b1;
                    n_f     = r_daddr;
                    n_pin   = rd_pin;
                    n_tag   = rd_tag;
                    n_state = S_ACT;
                end else if (!issue && !r_dvld) begin
                    n_hit   = 1'b0;
                    n_state = S_ACT;
                end
            end

            S_ACT: begin
                n_state = S_IDLE;
                case (r_kind)
                    KIND_FETCH, KIND_NEW: begin
                        if (r_hit && (r_kind == KIND_FETCH)) begin
                            ram_we        = 1'b1;
                            ram_wdata     = {pin_inc, r_tag};
                            rec_cmd.start = 1'b1;
                            rec_cmd.op    = REC_REMOVE;
                            n_state       = S_WAIT_REC;
                        end else if (r_hit) begin
                            n_o_valid = 1'b1;
                            n_res     = mk_res(1'b0, r_f, 1'b0, '0, 1'b0, 1'b0, 1'b1);
                        end else if (free_count != '0) begin
                            free_cmd.pop = 1'b1;
                            n_v          = free_head;
                            n_state      = S_INST_RD;
                        end else if (rec_rsp.nonempty) begin
                            rec_cmd.start = 1'b1;
                            rec_cmd.op    = REC_POP;
                            n_state       = S_WAIT_POP;
                        end else begin
                            n_o_valid = 1'b1;
                            n_res     = mk_res(1'b0, '0, 1'b0, '0, 1'b0, 1'b0, 1'b1);
                        end
                    end
                    KIND_UNPIN: begin
                        if (!r_hit) begin
                            n_o_valid = 1'b1;
                            n_res     = mk_res(1'b0, '0, 1'b0, '0, 1'b0, 1'b0, 1'b1);
                        end else if (r_pin == '0) begin
                            n_o_valid = 1'b1;
                            n_res     = mk_res(1'b0, r_f, 1'b0, '0, 1'b0, 1'b0, 1'b1);
                        end else begin
                            ram_we    = 1'b1;
                            ram_wdata = {pin_dec, r_tag};
                            if (r_mark) begin
                                n_dirty[r_f] = 1'b1;
                            end
                            if (pin_dec == '0) begin
                                rec_cmd.start = 1'b1;
                                rec_cmd.op    = REC_PUSH;
                                n_state       = S_WAIT_REC;
                            end else begin
                                n_o_valid = 1'b1;
                                n_res     = mk_res(1'b1, r_f, 1'b0, '0, 1'b0, 1'b0, 1'b1);
                            end
                        end
                    end
                    KIND_FLUSH: begin
                        n_o_valid = 1'b1;
                        if (!r_hit) begin
                            n_res = mk_res(1'b0, '0, 1'b0, '0, 1'b0, 1'b0, 1'b1);
                        end else begin
                            n_dirty[r_f] = 1'b0;
                            n_res = mk_res(1'b1, r_f, 1'b1, r_tag, 1'b0, 1'b0, 1'b1);
                        end
                    end
                    KIND_DELETE: begin
                        if (!r_hit) begin
                            n_o_valid = 1'b1;
                            n_res     = mk_res(1'b1, '0, 1'b0, '0, 1'b0, 1'b0, 1'b1);
                        end else if (r_pin != '0) begin
                            n_o_valid = 1'b1;
                            n_res     = mk_res(1'b0, r_f, 1'b0, '0, 1'b0, 1'b0, 1'b1);
                        end else begin
                            n_valid[r_f]  = 1'b0;
                            n_dirty[r_f]  = 1'b0;
                            free_cmd.push = 1'b1;
                            rec_cmd.start = 1'b1;
                            rec_cmd.op    = REC_REMOVE;
                            n_state       = S_WAIT_REC;
                        end
                    end
                    default: begin
                        n_o_valid = 1'b1;
                        n_res     = mk_res(1'b0, '0, 1'b0, '0, 1'b0, 1'b0, 1'b1);
                    end
                endcase
            end

            S_WAIT_REC: begin
                if (rec_rsp.done) begin
                    n_o_valid = 1'b1;
                    n_res     = mk_res(1'b1, r_f, 1'b0, '0, 1'b0, 1'b0, 1'b1);
                    n_state   = S_IDLE;
                end
            end

            S_WAIT_POP: begin
                if (rec_rsp.done) begin
                    n_v     = rec_frame;
                    n_state = S_INST_RD;
                end
            end

            // victim tag is read so a dirty victim can be written back
            S_INST_RD: begin
                n_state = S_INST_WR;
            end

            S_INST_WR: begin
                ram_we       = 1'b1;
                ram_waddr    = r_v;
                ram_wdata    = {PIN_ONE, r_pid};
                n_valid[r_v] = 1'b1;
                n_dirty[r_v] = 1'b0;
                n_o_valid    = 1'b1;
                n_res        = mk_res(1'b1, r_v, inst_wb, inst_wb ? rd_tag : '0,
                                      r_kind == KIND_FETCH, r_kind == KIND_NEW, 1'b1);
                n_state      = S_IDLE;
            end

            S_FLUSH: begin
                if (issue) begin
                    n_ptr  = r_ptr + 1'b1;
                    n_left = r_left - 1'b1;
                end
                n_dvld  = issue;
                n_daddr = r_ptr;
                if (r_dvld && vd[r_daddr]) begin
                    n_dirty[r_daddr] = 1'b0;
                    n_o_valid        = 1'b1;
                    n_res = mk_res(1'b1, r_daddr, 1'b1, rd_tag, 1'b0, 1'b0, flush_last);
                    n_k   = r_k + 1'b1;
                    if (flush_last) begin
                        n_state = S_IDLE;
                    end
                end else if (!issue && !r_dvld) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_left    <= '0;
            r_dvld    <= 1'b0;
            r_hit     <= 1'b0;
            r_valid   <= '0;
            r_dirty   <= '0;
            r_k       <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_left    <= n_left;
            r_dvld    <= n_dvld;
            r_hit     <= n_hit;
            r_valid   <= n_valid;
            r_dirty   <= n_dirty;
            r_k       <= n_k;
            r_o_valid <= n_o_valid;
        end
        r_kind  <= n_kind;
        r_pid   <= n_pid;
        r_mark  <= n_mark;
        r_ptr   <= n_ptr;
        r_daddr <= n_daddr;
        r_f     <= n_f;
        r_pin   <= n_pin;
        r_tag   <= n_tag;
        r_v     <= n_v;
        r_res   <= n_res;
    end

    assign busy              = (r_state != S_IDLE);
    assign o_valid           = r_o_valid;
    assign o_ok              = r_res.ok;
    assign o_frame           = r_res.frame;
    assign o_write_back      = r_res.wb;
    assign o_write_back_page = r_res.wbp;
    assign o_load_from_disk  = r_res.load;
    assign o_zero_fill       = r_res.zero;
    assign o_last            = r_res.last;

    `PFB_ASSERT_IMP(a_multi_only_flush, o_valid && !o_last, o_ok && o_write_back, "non-final result that is not a write back")
    `PFB_ASSERT_IMP(a_fill_is_install, o_valid && (o_load_from_disk || o_zero_fill), o_ok && o_last && !(o_load_from_disk && o_zero_fill), "bad install result")
    `PFB_ASSERT_IMP(a_frames_accounted, r_state == S_IDLE, $countones(r_valid) + int'(free_count) == FRAMES, "resident plus free frames lost count")
    `PFB_ASSERT_NXT(a_lookup_goes_busy, start && !busy && (i_kind == KIND_FETCH), busy && !o_valid, "fetch transfer did not start a search")

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top - page frame buffer LRU testbench
// Drives fetch / unpin / flush / new / delete / flush_all requests and
// checks every disk command against a scoreboard. The scoreboard keeps its
// own copy of the frame table, the free FIFO and the unpinned recency order.
// ---------------------------------------------------------------------------

module tb_top
    import pfb_pkg::*;
();

    localparam int NFRAMES      = FRAMES_DEF;
    localparam int PID_W        = PAGE_ID_BITS_DEF;
    localparam int PIN_CEIL     = (1 << PIN_BITS_DEF) - 1;
    localparam int NO_FRAME     = -1;
    localparam int PID_POOL_LEN = 24;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_CYCLES = 3 * NFRAMES + 8;

    // codes outside the request set; the block must answer with ok 0
    localparam logic [2:0] KIND_UNDEF_6 = 3'd6;
    localparam logic [2:0] KIND_UNDEF_7 = 3'd7;

    typedef struct packed {
        logic             ok;
        logic [3:0]       frame;
        logic             wb;
        logic [PID_W-1:0] wb_page;
        logic             load;
        logic             zero;
        logic             last;
    } t_disk_cmd;

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             start        = 1'b0;
    logic [2:0]       i_kind       = '0;
    logic [PID_W-1:0] i_page_id    = '0;
    logic             i_mark_dirty = 1'b0;
    logic             busy;
    logic             o_valid;
    logic             o_ok;
    logic [3:0]       o_frame;
    logic             o_write_back;
    logic [PID_W-1:0] o_write_back_page;
    logic             o_load_from_disk;
    logic             o_zero_fill;
    logic             o_last;

    page_frame_buffer_lru u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_kind            (i_kind),
        .i_page_id         (i_page_id),
        .i_mark_dirty      (i_mark_dirty),
        .o_valid           (o_valid),
        .o_ok              (o_ok),
        .o_frame           (o_frame),
        .o_write_back      (o_write_back),
        .o_write_back_page (o_write_back_page),
        .o_load_from_disk  (o_load_from_disk),
        .o_zero_fill       (o_zero_fill),
        .o_last            (o_last)
    );

    always #2 i_clk = ~i_clk;

    // scoreboard copy of the frame table
    logic [PID_W-1:0] frame_tag [NFRAMES];
    bit               frame_vld [NFRAMES];
    int unsigned      pin_cnt   [NFRAMES];
    bit               frame_drt [NFRAMES];
    bit               in_lru    [NFRAMES];
    int               free_fifo [$];
    int               lru_order [$];   // index 0 is the most recently unpinned

    t_disk_cmd        pending_cmds [$];
    t_disk_cmd        due_cmd;
    logic [PID_W-1:0] page_pool [PID_POOL_LEN];

    int unsigned gap_pct;
    int unsigned mismatches;
    int unsigned requests_sent;
    int unsigned cmds_checked;
    int unsigned idle_cycles;

    function automatic void table_reset();
        free_fifo.delete();
        lru_order.delete();
        for (int i = 0; i < NFRAMES; i++) begin
            frame_tag[i] = '0;
            frame_vld[i] = 1'b0;
            pin_cnt[i]   = 0;
            frame_drt[i] = 1'b0;
            in_lru[i]    = 1'b0;
            free_fifo    = {free_fifo, i};
        end
    endfunction

    function automatic void queue_cmd(bit ok, int frame, bit wb, logic [PID_W-1:0] wb_page,
                                      bit load, bit zero, bit last);
        t_disk_cmd c;
        c.ok      = ok;
        c.frame   = frame[3:0];
        c.wb      = wb;
        c.wb_page = wb ? wb_page : '0;
        c.load    = load;
        c.zero    = zero;
        c.last    = last;
        pending_cmds = {pending_cmds, c};
    endfunction

    function automatic int find_frame(logic [PID_W-1:0] pid);
        for (int i = 0; i < NFRAMES; i++)
            if (frame_vld[i] && frame_tag[i] == pid)
                return i;
        return NO_FRAME;
    endfunction

    function automatic void lru_drop(int f);
        if (!in_lru[f])
            return;
        for (int i = 0; i < lru_order.size(); i++) begin
            if (lru_order[i] == f) begin
                lru_order.delete(i);
                break;
            end
        end
        in_lru[f] = 1'b0;
    endfunction

    // victim: free FIFO head first, then least recently unpinned frame
    function automatic void install_page(logic [PID_W-1:0] pid, bit zero);
        int v = NO_FRAME;
        bit wb = 1'b0;
        if (free_fifo.size() != 0) begin
            v = free_fifo[0];
            free_fifo.delete(0);
        end else if (lru_order.size() != 0) begin
            v = lru_order[lru_order.size() - 1];
            lru_order.delete(lru_order.size() - 1);
            in_lru[v] = 1'b0;
        end
        if (v == NO_FRAME) begin
            queue_cmd(0, 0, 0, '0, 0, 0, 1);
            return;
        end
        wb = frame_vld[v] && frame_drt[v];
        queue_cmd(1, v, wb, frame_tag[v], !zero, zero, 1);
        frame_tag[v] = pid;
        frame_vld[v] = 1'b1;
        frame_drt[v] = 1'b0;
        pin_cnt[v]   = 1;
    endfunction

    function automatic void compute_disk_cmds(logic [2:0] kind, logic [PID_W-1:0] pid,
                                              logic mark);
        int f = find_frame(pid);
        int dirty_frames [$];
        case (kind)
            KIND_FETCH: begin
                if (f != NO_FRAME) begin
                    if (pin_cnt[f] < PIN_CEIL)
                        pin_cnt[f]++;
                    lru_drop(f);
                    queue_cmd(1, f, 0, '0, 0, 0, 1);
                end else begin
                    install_page(pid, 1'b0);
                end
            end
            KIND_UNPIN: begin
                if (f == NO_FRAME || pin_cnt[f] == 0) begin
                    queue_cmd(0, (f == NO_FRAME) ? 0 : f, 0, '0, 0, 0, 1);
                end else begin
                    pin_cnt[f]--;
                    if (mark)
                        frame_drt[f] = 1'b1;
                    if (pin_cnt[f] == 0 && !in_lru[f]) begin
                        lru_order = {f, lru_order};
                        in_lru[f] = 1'b1;
                    end
                    queue_cmd(1, f, 0, '0, 0, 0, 1);
                end
            end
            KIND_FLUSH: begin
                if (f == NO_FRAME) begin
                    queue_cmd(0, 0, 0, '0, 0, 0, 1);
                end else begin
                    frame_drt[f] = 1'b0;
                    queue_cmd(1, f, 1, frame_tag[f], 0, 0, 1);
                end
            end
            KIND_NEW: begin
                if (f != NO_FRAME)
                    queue_cmd(0, f, 0, '0, 0, 0, 1);
                else
                    install_page(pid, 1'b1);
            end
            KIND_DELETE: begin
                if (f == NO_FRAME) begin
                    queue_cmd(1, 0, 0, '0, 0, 0, 1);
                end else if (pin_cnt[f] > 0) begin
                    queue_cmd(0, f, 0, '0, 0, 0, 1);
                end else begin
                    lru_drop(f);
                    frame_vld[f] = 1'b0;
                    frame_drt[f] = 1'b0;
                    frame_tag[f] = '0;
                    if (free_fifo.size() < NFRAMES)
                        free_fifo = {free_fifo, f};
                    queue_cmd(1, f, 0, '0, 0, 0, 1);
                end
            end
            KIND_FLUSH_ALL: begin
                for (int i = 0; i < NFRAMES; i++)
                    if (frame_vld[i] && frame_drt[i] && dirty_frames.size() < MAX_RESULTS)
                        dirty_frames = {dirty_frames, i};
                if (dirty_frames.size() == 0)
                    queue_cmd(1, 0, 0, '0, 0, 0, 1);
                for (int i = 0; i < dirty_frames.size(); i++) begin
                    frame_drt[dirty_frames[i]] = 1'b0;
                    queue_cmd(1, dirty_frames[i], 1, frame_tag[dirty_frames[i]], 0, 0,
                              i == dirty_frames.size() - 1);
                end
            end
            default: begin
                queue_cmd(0, 0, 0, '0, 0, 0, 1);
            end
        endcase
    endfunction

    // one request transfer; start stays high for the next call unless a gap is drawn
    task automatic send_request(logic [2:0] kind, logic [PID_W-1:0] pid, logic mark);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_kind       <= kind;
        i_page_id    <= pid;
        i_mark_dirty <= mark;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        compute_disk_cmds(kind, pid, mark);
        requests_sent++;
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_cmds.size() != 0 || busy)
            @(posedge i_clk);
    endtask

    function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (exp !== act) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_cmds.size() == 0) begin
                $error("result transfer with nothing outstanding (frame %0d)", o_frame);
                mismatches++;
            end else begin
                due_cmd = pending_cmds[0];
                pending_cmds.delete(0);
                check_field("ok", 32'(due_cmd.ok), 32'(o_ok));
                check_field("frame", 32'(due_cmd.frame), 32'(o_frame));
                check_field("write_back", 32'(due_cmd.wb), 32'(o_write_back));
                check_field("write_back_page", 32'(due_cmd.wb_page), 32'(o_write_back_page));
                check_field("load_from_disk", 32'(due_cmd.load), 32'(o_load_from_disk));
                check_field("zero_fill", 32'(due_cmd.zero), 32'(o_zero_fill));
                check_field("last", 32'(due_cmd.last), 32'(o_last));
                cmds_checked++;
            end
        end
    end

    initial begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_valid)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $error("no transfer for %0d cycles", STALL_LIMIT);
        $display("tb_top: done, errors");
        $finish;
    end

    // requests that find nothing, and codes outside the request set
    task automatic test_empty_pool();
        send_request(KIND_FLUSH_ALL, '0, 1'b0);
        send_request(KIND_UNPIN, 24'h000001, 1'b1);
        send_request(KIND_FLUSH, 24'h000002, 1'b0);
        send_request(KIND_DELETE, 24'h000003, 1'b0);
        send_request(KIND_UNDEF_6, 24'hFFFFFF, 1'b1);
        send_request(KIND_UNDEF_7, 24'h000000, 1'b0);
    endtask

    task automatic test_page_lifecycle();
        send_request(KIND_FETCH, 24'h000000, 1'b0);
        send_request(KIND_NEW, 24'hFFFFFF, 1'b0);
        send_request(KIND_NEW, 24'h000000, 1'b0);     // already resident
        send_request(KIND_DELETE, 24'h000000, 1'b0);  // still pinned
        send_request(KIND_UNPIN, 24'hFFFFFF, 1'b1);
        send_request(KIND_UNPIN, 24'hFFFFFF, 1'b0);   // pin already zero
        send_request(KIND_FLUSH, 24'hFFFFFF, 1'b0);
        send_request(KIND_FLUSH, 24'hFFFFFF, 1'b0);   // clean frame still written
        send_request(KIND_FETCH, 24'hFFFFFF, 1'b0);   // hit leaves the recency list
        send_request(KIND_UNPIN, 24'hFFFFFF, 1'b1);
        send_request(KIND_FLUSH_ALL, '0, 1'b0);
        send_request(KIND_DELETE, 24'hFFFFFF, 1'b0);
        send_request(KIND_FETCH, 24'hFFFFFF, 1'b0);   // freed frame waits at the FIFO tail
        send_request(KIND_UNPIN, 24'hFFFFFF, 1'b0);
    endtask

    // fill every frame, fail a miss, then evict from the recency tail
    task automatic test_eviction();
        for (int i = 0; i < NFRAMES; i++)
            send_request(KIND_FETCH, PID_W'(24'h800000 | i), 1'b0);
        send_request(KIND_FETCH, 24'h123456, 1'b0);
        send_request(KIND_NEW, 24'h123457, 1'b0);
        send_request(KIND_UNPIN, 24'h000000, 1'b1);
        for (int i = 0; i < NFRAMES; i++)
            send_request(KIND_UNPIN, PID_W'(24'h800000 | i), i[0]);
        send_request(KIND_FETCH, 24'h123456, 1'b0);
        send_request(KIND_NEW, 24'h123457, 1'b0);
        send_request(KIND_UNPIN, 24'h123456, 1'b1);
        send_request(KIND_UNPIN, 24'h123457, 1'b0);
        send_request(KIND_FLUSH_ALL, '0, 1'b0);
    endtask

    // every frame dirty: flush_all gives its longest burst
    task automatic test_flush_all_burst();
        for (int i = 0; i < NFRAMES; i++) begin
            send_request(KIND_FETCH, PID_W'(24'hC00000 | i), 1'b0);
            send_request(KIND_UNPIN, PID_W'(24'hC00000 | i), 1'b1);
        end
        send_request(KIND_FLUSH_ALL, '0, 1'b0);
        send_request(KIND_FLUSH_ALL, '0, 1'b0);
    endtask

    task automatic test_random_traffic(int unsigned count, int unsigned pct);
        int unsigned      pinned;
        int unsigned      pick;
        int               f;
        logic [PID_W-1:0] pid;
        gap_pct = pct;
        repeat (count) begin
            pinned = 0;
            for (int i = 0; i < NFRAMES; i++)
                if (frame_vld[i] && pin_cnt[i] != 0)
                    pinned++;
            pid  = page_pool[$urandom_range(PID_POOL_LEN - 1)];
            pick = $urandom_range(99);
            if (pick < ((pinned >= 12) ? 55 : 28)) begin
                f = $urandom_range(NFRAMES - 1);
                for (int s = 0; s < NFRAMES; s++) begin
                    if (frame_vld[(f + s) % NFRAMES] && pin_cnt[(f + s) % NFRAMES] != 0) begin
                        pid = frame_tag[(f + s) % NFRAMES];
                        break;
                    end
                end
                send_request(KIND_UNPIN, pid, 1'($urandom_range(1)));
            end else begin
                pick = $urandom_range(99);
                if (pick < 50)
                    send_request(KIND_FETCH, pid, 1'($urandom_range(1)));
                else if (pick < 62)
                    send_request(KIND_FLUSH, pid, 1'b0);
                else if (pick < 74)
                    send_request(KIND_NEW, pid, 1'b0);
                else if (pick < 86)
                    send_request(KIND_DELETE, pid, 1'b0);
                else if (pick < 92)
                    send_request(KIND_FLUSH_ALL, '0, 1'b0);
                else
                    send_request(3'($urandom_range(7)), PID_W'($urandom),
                                 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        mismatches    = 0;
        requests_sent = 0;
        cmds_checked  = 0;
        gap_pct       = 0;
        table_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_pool();
        test_page_lifecycle();
        gap_pct = 46;
        test_eviction();
        gap_pct = 0;
        test_flush_all_burst();
        wait_quiet();

        for (int i = 0; i < PID_POOL_LEN; i++)
            page_pool[i] = PID_W'($urandom);
        test_random_traffic(70, 0);
        test_random_traffic(70, 46);
        test_random_traffic(70, 28);

        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("tb_top: %0d requests sent, %0d disk commands checked", requests_sent,
                 cmds_checked);
        $display("tb_top: lookups, evictions, flush bursts, bad codes, idle gaps");
        if (mismatches == 0 && pending_cmds.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            if (pending_cmds.size() != 0)
                $error("%0d expected results never arrived", pending_cmds.size());
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/pfb_pkg.sv
design/pfb_ram.sv
design/pfb_free_fifo.sv
design/pfb_recency.sv
design/page_frame_buffer_lru.sv
test/tb_top.sv
